// File: rtl/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg: shared types and constants for the positional list store
// Sizes of the cell chain, command and status codes, cell operations and
// the control group that the top level hands to the cell chain.
// ----------------------------------------------------------------------------
package plm_pkg;

    // Storage size and element width.
    localparam int DEPTH = 16;
    localparam int WIDTH = 32;

    // Fixed field widths of the request and result channels.
    localparam int CMD_W   = 3;
    localparam int INDEX_W = 4;
    localparam int CFG_W   = 5;
    localparam int OUT_N_W = 5;
    localparam int STAT_W  = 2;

    // Internal widths derived from the depth.
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    // Reset value of the initial capacity register.
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR       = 3'd0,
        CMD_INSERT_AT   = 3'd1,
        CMD_APPEND      = 3'd2,
        CMD_DELETE_AT   = 3'd3,
        CMD_DELETE_LAST = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // What one cell does at the next clock edge.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD_NEW,
        OP_FROM_LOW,
        OP_FROM_HIGH
    } t_cell_op;

    // Shift command from the control logic to the cell chain.
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  cnt;
        logic [WIDTH-1:0]  value;
    } t_chain_cmd;

    // Capacity loaded on reset and on clear, clamped to 1..DEPTH.
    function automatic logic [CNT_W-1:0] load_cap(input logic [CFG_W-1:0] cfg);
        logic [CNT_W-1:0] res;
        if (cfg == '0) begin
            res = CNT_W'(1);
        end else if (int'(cfg) > DEPTH) begin
            res = CNT_W'(DEPTH);
        end else begin
            res = CNT_W'(cfg);
        end
        return res;
    endfunction

endpackage

// File: rtl/plm_if.sv
// ----------------------------------------------------------------------------
// plm_if: channel interfaces of the positional list store
// Request, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface plm_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [plm_pkg::CMD_W-1:0]      command;
    logic [plm_pkg::INDEX_W-1:0]    index;
    logic [plm_pkg::WIDTH-1:0]      element_value;

    modport source (output valid, output command, output index, output element_value,
                    input ready);
    modport sink   (input valid, input command, input index, input element_value,
                    output ready);
endinterface

interface plm_res_if;
    logic                           valid;
    logic                           ready;
    logic [plm_pkg::WIDTH-1:0]      removed_value;
    logic [plm_pkg::OUT_N_W-1:0]    element_count;
    logic [plm_pkg::OUT_N_W-1:0]    logical_capacity;
    logic [plm_pkg::STAT_W-1:0]     status;

    modport source (output valid, output removed_value, output element_count,
                    output logical_capacity, output status, input ready);
    modport sink   (input valid, input removed_value, input element_count,
                    input logical_capacity, input status, output ready);
endinterface

interface plm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [plm_pkg::CFG_W-1:0]      initial_capacity;

    modport source (output valid, output initial_capacity, input ready);
    modport sink   (input valid, input initial_capacity, output ready);
endinterface

// File: rtl/positional_list_insert_delete_top.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top: ordered list store with tracked capacity
// Clear, insert at, append, delete at and delete last on a chain of cells,
// with a logical capacity that doubles when full and halves when sparse.
//
//   Channel   Direction  Contents
//   i_cmd     in         command, index, element_value
//   o_res     out        removed_value, element_count, logical_capacity, status
//   i_cfg     in         initial_capacity (always ready)
//
// Each request is decoded and applied to the cell chain in the cycle it is
// accepted; all cells shift together, so one request per cycle is taken.
// The result is captured in the output register when the request is accepted.
// A new request is taken while a result waits only if o_res.ready is high.
// Reset empties the list and loads the capacity from the register value 4.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plm_cmd_if.sink     i_cmd,
    plm_res_if.source   o_res,
    plm_cfg_if.sink     i_cfg
);
    import plm_pkg::*;

    logic [CFG_W-1:0]  r_init_cap;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  n_cap;
    logic              r_out_valid;
    logic [WIDTH-1:0]  r_removed;
    logic [WIDTH-1:0]  n_removed;
    logic [CNT_W-1:0]  r_out_count;
    logic [CNT_W-1:0]  r_out_cap;
    t_status           r_status;
    t_status           n_status;

    logic              accept;
    logic              do_ins;
    logic              do_del;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  cnt_ext;
    logic [CNT_W:0]    cap_dbl;
    logic [WIDTH-1:0]  chain_removed;
    t_chain_cmd        chain_cmd;

    assign accept      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign i_cfg.ready = 1'b1;
    assign cnt_ext     = POS_W'(r_count);
    assign cap_dbl     = {r_cap, 1'b0};

    // Command decode, error checks and capacity tracking.
    always_comb begin
        do_ins    = 1'b0;
        do_del    = 1'b0;
        pos       = POS_W'(i_cmd.index);
        n_count   = r_count;
        n_cap     = r_cap;
        n_removed = '0;
        n_status  = ST_OK;
        unique case (t_cmd'(i_cmd.command))
            CMD_CLEAR: begin
                n_count = '0;
                n_cap   = load_cap(r_init_cap);
            end
            CMD_INSERT_AT, CMD_APPEND: begin
                if (t_cmd'(i_cmd.command) == CMD_APPEND) begin
                    pos = cnt_ext;
                end
                if (pos > cnt_ext) begin
                    n_status = ST_BAD_INDEX;
                end else if (int'(r_count) >= DEPTH) begin
                    n_status = ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (r_count >= r_cap) begin
                        n_cap = (int'(cap_dbl) > DEPTH) ? CNT_W'(DEPTH)
                                                        : CNT_W'(cap_dbl);
                    end
                end
            end
            CMD_DELETE_AT, CMD_DELETE_LAST: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    if (t_cmd'(i_cmd.command) == CMD_DELETE_LAST) begin
                        pos = cnt_ext - POS_W'(1);
                    end
                    if (pos >= cnt_ext) begin
                        n_status = ST_BAD_INDEX;
                    end else begin
                        do_del    = 1'b1;
                        n_removed = chain_removed;
                        n_count   = r_count - CNT_W'(1);
                        if (n_count < (r_cap >> 2)) begin
                            n_cap = r_cap - (r_cap >> 1);
                        end
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Shift request to the cell chain, only for an accepted request.
    assign chain_cmd.ins   = do_ins && accept;
    assign chain_cmd.del   = do_del && accept;
    assign chain_cmd.pos   = pos;
    assign chain_cmd.cnt   = cnt_ext;
    assign chain_cmd.value = i_cmd.element_value;

    plm_chain u_chain (
        .i_clk     (i_clk),
        .i_cmd     (chain_cmd),
        .o_removed (chain_removed)
    );

    // Configuration register, list count and capacity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_cap <= CFG_RESET;
            r_count    <= '0;
            r_cap      <= load_cap(CFG_RESET);
        end else begin
            if (i_cfg.valid) begin
                r_init_cap <= i_cfg.initial_capacity;
            end
            if (accept) begin
                r_count <= n_count;
                r_cap   <= n_cap;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_removed   <= n_removed;
            r_out_count <= n_count;
            r_out_cap   <= n_cap;
            r_status    <= n_status;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.removed_value    = r_removed;
    assign o_res.element_count    = OUT_N_W'(r_out_count);
    assign o_res.logical_capacity = OUT_N_W'(r_out_cap);
    assign o_res.status           = r_status;

endmodule

// File: rtl/plm_cell.sv
// ----------------------------------------------------------------------------
// plm_cell: one storage cell of the list chain
// Holds one element and loads a new value, its lower neighbour or its upper
// neighbour as the chain control selects.
// ----------------------------------------------------------------------------
module plm_cell (
    input  logic                        i_clk,
    input  plm_pkg::t_cell_op           i_op,
    input  logic [plm_pkg::WIDTH-1:0]   i_new,
    input  logic [plm_pkg::WIDTH-1:0]   i_low,
    input  logic [plm_pkg::WIDTH-1:0]   i_high,
    output logic [plm_pkg::WIDTH-1:0]   o_value
);
    import plm_pkg::*;

    logic [WIDTH-1:0] r_value;
    logic [WIDTH-1:0] n_value;

    // Select the next content of the cell.
    always_comb begin
        unique case (i_op)
            OP_LOAD_NEW:  n_value = i_new;
            OP_FROM_LOW:  n_value = i_low;
            OP_FROM_HIGH: n_value = i_high;
            default:      n_value = r_value;
        endcase
    end

    // Element storage; contents are only read after being written.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// File: rtl/plm_chain.sv
// ----------------------------------------------------------------------------
// plm_chain: row of list cells with per-cell shift control
// Decodes an insert or delete into one operation per cell, so that all
// later elements move one place together, and returns the element
// at the delete position.
// ----------------------------------------------------------------------------
module plm_chain (
    input  logic                        i_clk,
    input  plm_pkg::t_chain_cmd         i_cmd,
    output logic [plm_pkg::WIDTH-1:0]   o_removed
);
    import plm_pkg::*;

    logic [WIDTH-1:0] cell_value [DEPTH];
    t_cell_op         cell_op    [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            localparam logic [POS_W-1:0] POS_I   = POS_W'(gi);
            localparam logic [POS_W:0]   POS_INC = (POS_W + 1)'(gi + 1);

            logic [WIDTH-1:0] low_value;
            logic [WIDTH-1:0] high_value;

            // Per-cell operation: insert opens a gap at pos, delete closes it.
            always_comb begin
                cell_op[gi] = OP_HOLD;
                if (i_cmd.ins) begin
                    if (POS_I == i_cmd.pos) begin
                        cell_op[gi] = OP_LOAD_NEW;
                    end else if (POS_I > i_cmd.pos && POS_I <= i_cmd.cnt) begin
                        cell_op[gi] = OP_FROM_LOW;
                    end
                end else if (i_cmd.del) begin
                    if (POS_I >= i_cmd.pos && POS_INC < {1'b0, i_cmd.cnt}) begin
                        cell_op[gi] = OP_FROM_HIGH;
                    end
                end
            end

            // Neighbour taps; the ends of the chain see zero.
            if (gi == 0) begin : g_first
                assign low_value = '0;
            end else begin : g_inner_low
                assign low_value = cell_value[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign high_value = '0;
            end else begin : g_inner_high
                assign high_value = cell_value[gi+1];
            end

            plm_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (cell_op[gi]),
                .i_new   (i_cmd.value),
                .i_low   (low_value),
                .i_high  (high_value),
                .o_value (cell_value[gi])
            );
        end
    endgenerate

    // Element at the delete position; pos is below count there.
    assign o_removed = cell_value[i_cmd.pos[ADDR_W-1:0]];

endmodule

// File: rtl/plm_checker.sv
// ----------------------------------------------------------------------------
// plm_checker: port-level checks for the positional list store
// Watches the request and result channels of the top level and checks
// result ordering and the ranges of the reported list state.
// ----------------------------------------------------------------------------
module plm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  logic                          i_cmd_ready,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic [plm_pkg::WIDTH-1:0]     i_removed_value,
    input  logic [plm_pkg::OUT_N_W-1:0]   i_element_count,
    input  logic [plm_pkg::OUT_N_W-1:0]   i_logical_capacity,
    input  logic [plm_pkg::STAT_W-1:0]    i_status
);
    import plm_pkg::*;

    // A result that is not taken stays offered.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result withdrawn while stalled");

    // Every accepted request produces a result in the next cycle.
    a_req_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> i_res_valid)
        else $error("accepted request gave no result");

    // The list never holds more than the store depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> int'(i_element_count) <= DEPTH)
        else $error("element count above depth");

    // The tracked capacity stays within one and the depth.
    a_cap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_logical_capacity != '0) && int'(i_logical_capacity) <= DEPTH)
        else $error("logical capacity out of range");

    // A failed request removes nothing.
    a_err_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_status != ST_OK) |-> i_removed_value == '0)
        else $error("removed value on error status");

endmodule

bind positional_list_insert_delete_top plm_checker u_plm_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_cmd_valid        (i_cmd.valid),
    .i_cmd_ready        (i_cmd.ready),
    .i_res_valid        (o_res.valid),
    .i_res_ready        (o_res.ready),
    .i_removed_value    (o_res.removed_value),
    .i_element_count    (o_res.element_count),
    .i_logical_capacity (o_res.logical_capacity),
    .i_status           (o_res.status)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the positional list store
// Drives clear, insert, append and delete requests through the command
// channel, mirrors the list and its logical capacity, and compares every
// result with the mirrored outcome. Sender idling, receiver stalls and a long
// receiver hold-off are mixed in, and the initial capacity register is
// written at several settings, the out-of-range ones among them.
// ----------------------------------------------------------------------------
module testbench;
    import plm_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int HOLD_OFF_LEN   = 64;
    localparam int PRINT_LIMIT    = 100;

    // Command codes that the block does not recognise.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic [WIDTH-1:0]   removed_value;
        logic [OUT_N_W-1:0] element_count;
        logic [OUT_N_W-1:0] logical_capacity;
        logic [STAT_W-1:0]  status;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    plm_cmd_if cmd_if ();
    plm_res_if res_if ();
    plm_cfg_if cfg_if ();

    positional_list_insert_delete_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // Mirror of the list contents, its count, capacity and register.
    logic [WIDTH-1:0] mirror_cells [DEPTH];
    int               mirror_count;
    int               mirror_capacity;
    logic [CFG_W-1:0] mirror_init_cap;

    t_list_result pending_results [$];

    int mismatch_count;
    int printed_lines;
    int requests_sent;
    int results_checked;
    int cfg_writes;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_cycles_asked;
    int hold_left;

    // Free-running clock.
    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Capacity that a clear or a reset loads from the register.
    function automatic int capacity_after_load(input logic [CFG_W-1:0] cfg);
        int c;
        c = int'(cfg);
        if (c < 1) begin
            c = 1;
        end else if (c > DEPTH) begin
            c = DEPTH;
        end
        return c;
    endfunction

    // Applies one request to the mirror and returns the outcome it gives.
    function automatic t_list_result apply_list_command(input logic [CMD_W-1:0] cmd,
                                                        input logic [INDEX_W-1:0] idx,
                                                        input logic [WIDTH-1:0] val);
        t_list_result r;
        int pos;
        r.removed_value = '0;
        r.status        = ST_OK;
        case (cmd)
            CMD_CLEAR: begin
                mirror_count    = 0;
                mirror_capacity = capacity_after_load(mirror_init_cap);
            end
            CMD_INSERT_AT, CMD_APPEND: begin
                pos = (cmd == CMD_APPEND) ? mirror_count : int'(idx);
                if (pos > mirror_count) begin
                    r.status = ST_BAD_INDEX;
                end else if (mirror_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // A full list doubles its capacity, up to the depth.
                    if (mirror_count >= mirror_capacity) begin
                        mirror_capacity = (2 * mirror_capacity > DEPTH) ?
                                          DEPTH : 2 * mirror_capacity;
                    end
                    for (int i = mirror_count; i > pos; i--) begin
                        mirror_cells[i] = mirror_cells[i-1];
                    end
                    mirror_cells[pos] = val;
                    mirror_count++;
                end
            end
            CMD_DELETE_AT, CMD_DELETE_LAST: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = (cmd == CMD_DELETE_LAST) ? mirror_count - 1 : int'(idx);
                    if (pos >= mirror_count) begin
                        r.status = ST_BAD_INDEX;
                    end else begin
                        r.removed_value = mirror_cells[pos];
                        for (int i = pos; i + 1 < mirror_count; i++) begin
                            mirror_cells[i] = mirror_cells[i+1];
                        end
                        mirror_count--;
                        // A sparse list gives back half of its capacity.
                        if (mirror_count < mirror_capacity / 4) begin
                            mirror_capacity = mirror_capacity - mirror_capacity / 2;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.element_count    = OUT_N_W'(mirror_count);
        r.logical_capacity = OUT_N_W'(mirror_capacity);
        return r;
    endfunction

    // Element values lean towards the extremes now and then.
    function automatic logic [WIDTH-1:0] pick_element_value();
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return WIDTH'($urandom);
    endfunction

    // Offers one request, after any random idle cycles, and records its outcome.
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [INDEX_W-1:0] idx,
                                input logic [WIDTH-1:0] val);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            cmd_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        cmd_if.valid         <= 1'b1;
        cmd_if.command       <= cmd;
        cmd_if.index         <= idx;
        cmd_if.element_value <= val;
        do @(posedge i_clk); while (!cmd_if.ready);
        pending_results.push_back(apply_list_command(cmd, idx, val));
        requests_sent++;
    endtask

    // Stops offering and waits until every outcome has been checked.
    task automatic wait_for_idle();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Writes the initial capacity register while the list is idle.
    task automatic write_initial_capacity(input logic [CFG_W-1:0] value);
        wait_for_idle();
        @(negedge i_clk);
        cfg_if.valid            <= 1'b1;
        cfg_if.initial_capacity <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        mirror_init_cap = value;
        cfg_writes++;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic report_field(input string name, input logic [WIDTH-1:0] exp_val,
                                input logic [WIDTH-1:0] act_val);
        mismatch_count++;
        if (printed_lines < PRINT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            printed_lines++;
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when one is asked for.
    always @(negedge i_clk) begin
        if (hold_cycles_asked > 0) begin
            hold_left         = hold_cycles_asked;
            hold_cycles_asked = 0;
        end
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else begin
            res_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Result checker: each accepted result against the oldest outcome.
    always @(posedge i_clk) begin
        t_list_result exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (printed_lines < PRINT_LIMIT) begin
                    $display("%0t: result with no request waiting, actual count %0d",
                             $time, res_if.element_count);
                    printed_lines++;
                end
            end else begin
                exp_res = pending_results.pop_front();
                results_checked++;
                if (res_if.removed_value !== exp_res.removed_value) begin
                    report_field("removed_value", exp_res.removed_value,
                                 res_if.removed_value);
                end
                if (res_if.element_count !== exp_res.element_count) begin
                    report_field("element_count", WIDTH'(exp_res.element_count),
                                 WIDTH'(res_if.element_count));
                end
                if (res_if.logical_capacity !== exp_res.logical_capacity) begin
                    report_field("logical_capacity", WIDTH'(exp_res.logical_capacity),
                                 WIDTH'(res_if.logical_capacity));
                end
                if (res_if.status !== exp_res.status) begin
                    report_field("status", WIDTH'(exp_res.status), WIDTH'(res_if.status));
                end
            end
        end
    end

    // Errors on an empty list: both deletes and inserts past the end.
    task automatic test_empty_list_errors();
        send_request(CMD_DELETE_AT, 4'd0, '1);
        send_request(CMD_DELETE_LAST, 4'd15, '0);
        send_request(CMD_INSERT_AT, 4'd1, 32'h1234_5678);
        send_request(CMD_INSERT_AT, 4'd15, '1);
    endtask

    // Inserts and deletes at the ends and in the middle, bad indexes, spare codes.
    task automatic test_positions();
        send_request(CMD_APPEND, 4'd0, '0);
        send_request(CMD_APPEND, 4'd9, '1);
        send_request(CMD_INSERT_AT, 4'd0, 32'hA5A5_A5A5);
        send_request(CMD_INSERT_AT, 4'd3, 32'h5A5A_5A5A);
        send_request(CMD_INSERT_AT, 4'd1, 32'h0000_0001);
        send_request(CMD_INSERT_AT, 4'd7, 32'h8000_0000);
        send_request(CMD_DELETE_AT, 4'd5, '0);
        send_request(CMD_DELETE_AT, 4'd15, '0);
        send_request(CMD_DELETE_AT, 4'd2, '0);
        send_request(CMD_DELETE_AT, 4'd0, '0);
        send_request(CMD_DELETE_LAST, 4'd0, '0);
        for (int c = int'(CMD_SPARE_LO); c <= int'(CMD_SPARE_HI); c++) begin
            send_request(CMD_W'(c), INDEX_W'($urandom), pick_element_value());
        end
        send_request(CMD_CLEAR, 4'd15, '1);
    endtask

    // Capacity doubling up to the depth, full store, then shrinking on drain.
    task automatic test_growth_and_shrink();
        write_initial_capacity(CFG_W'(1));
        send_request(CMD_CLEAR, 4'd0, '0);
        repeat (DEPTH) send_request(CMD_APPEND, 4'd0, pick_element_value());
        send_request(CMD_APPEND, 4'd0, '1);
        send_request(CMD_INSERT_AT, 4'd3, '1);
        send_request(CMD_INSERT_AT, 4'd15, '0);
        send_request(CMD_DELETE_AT, 4'd15, '0);
        send_request(CMD_DELETE_AT, 4'd15, '0);
        while (mirror_count > 0) send_request(CMD_DELETE_LAST, 4'd0, '0);
        send_request(CMD_DELETE_LAST, 4'd0, '0);
    endtask

    // Out-of-range register values clamp at the next clear.
    task automatic test_register_extremes();
        write_initial_capacity(CFG_W'(0));
        send_request(CMD_CLEAR, 4'd0, '0);
        send_request(CMD_APPEND, 4'd0, pick_element_value());
        send_request(CMD_APPEND, 4'd0, pick_element_value());
        write_initial_capacity(CFG_W'(31));
        send_request(CMD_APPEND, 4'd0, pick_element_value());
        send_request(CMD_CLEAR, 4'd0, '0);
        send_request(CMD_APPEND, 4'd0, pick_element_value());
        write_initial_capacity(CFG_W'(17));
        send_request(CMD_CLEAR, 4'd0, '0);
    endtask

    // Random traffic: mostly well-formed requests that sweep the list between
    // empty and full, with some clears, spare codes and bad indexes mixed in.
    task automatic test_random_traffic(input int n_items);
        int  sent;
        int  r;
        int  top;
        bit  filling;
        sent    = 0;
        filling = 1'b1;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 3) begin
                send_request(CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)),
                             INDEX_W'($urandom), WIDTH'($urandom));
            end else begin
                if (r < 5) begin
                    send_request(CMD_CLEAR, INDEX_W'($urandom), WIDTH'($urandom));
                end else if (r < 13) begin
                    send_request(CMD_W'($urandom_range(CMD_DELETE_LAST, CMD_INSERT_AT)),
                                 INDEX_W'($urandom), pick_element_value());
                end else if (filling == ($urandom_range(99) < 70)) begin
                    top = (mirror_count > DEPTH - 1) ? DEPTH - 1 : mirror_count;
                    if ($urandom_range(1)) begin
                        send_request(CMD_INSERT_AT, INDEX_W'($urandom_range(top)),
                                     pick_element_value());
                    end else begin
                        send_request(CMD_APPEND, INDEX_W'($urandom), pick_element_value());
                    end
                end else begin
                    if (mirror_count > 0 && $urandom_range(1)) begin
                        send_request(CMD_DELETE_AT,
                                     INDEX_W'($urandom_range(mirror_count - 1)),
                                     WIDTH'($urandom));
                    end else begin
                        send_request(CMD_DELETE_LAST, INDEX_W'($urandom), WIDTH'($urandom));
                    end
                end
                sent++;
            end
            // Turn round at the ends, sometimes only after hitting an error.
            if (mirror_count == DEPTH && $urandom_range(1)) begin
                filling = 1'b0;
            end else if (mirror_count == 0 && $urandom_range(1)) begin
                filling = 1'b1;
            end else if ($urandom_range(99) < 4) begin
                filling = !filling;
            end
        end
    endtask

    // A random phase at one register setting and one idling pattern.
    task automatic test_idle_phase(input logic [CFG_W-1:0] cap_setting, input int idle_pct,
                                   input int stall_pct, input int n_items);
        write_initial_capacity(cap_setting);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        send_request(CMD_CLEAR, 4'd0, '0);
        test_random_traffic(n_items);
    endtask

    // Long receiver hold-off while requests keep coming, so the input stalls.
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        @(negedge i_clk);
        cmd_if.valid      <= 1'b0;
        hold_cycles_asked = HOLD_OFF_LEN;
        test_random_traffic(40);
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        cmd_if.valid            = 1'b0;
        cmd_if.command          = CMD_CLEAR;
        cmd_if.index            = '0;
        cmd_if.element_value    = '0;
        res_if.ready            = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.initial_capacity = '0;
        mismatch_count          = 0;
        printed_lines           = 0;
        requests_sent           = 0;
        results_checked         = 0;
        cfg_writes              = 0;
        sender_idle_pct         = 0;
        receiver_stall_pct      = 0;
        hold_cycles_asked       = 0;
        hold_left               = 0;
        mirror_init_cap         = CFG_RESET;
        mirror_count            = 0;
        mirror_capacity         = capacity_after_load(CFG_RESET);
        for (int i = 0; i < DEPTH; i++) begin
            mirror_cells[i] = '0;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list_errors();
        test_positions();
        test_growth_and_shrink();
        test_register_extremes();
        test_idle_phase(CFG_W'(16), 0, 0, 80);
        test_idle_phase(CFG_W'(2), 58, 0, 80);
        test_idle_phase(CFG_W'(3), 0, 58, 80);
        test_idle_phase(CFG_W'($urandom_range(16, 1)), 32, 32, 80);
        test_backpressure();
        wait_for_idle();

        $display("Ran %0d requests and checked %0d results over %0d register writes,",
                 requests_sent, results_checked, cfg_writes);
        $display("with idle, stall and hold-off phases and the list swept empty to full.");
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("Timed out with %0d results still awaited.", pending_results.size());
        $display("tb: failure");
        $finish;
    end

endmodule
